>>> hw/rtl/tat_pkg.sv
// Shared types, constants and the sine table of the triangle affine transform.
// Depends on nothing; the lane, merge and top-level files import it.
package tat_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int TRIG_FRAC_BITS  = 14;
    localparam int SCALE_FRAC_BITS = 8;
    localparam int NUM_VERTICES    = 3;
    localparam int NUM_COORDS      = 2 * NUM_VERTICES;
    localparam int ANGLE_WIDTH     = 9;
    localparam int ANGLE_WRAP      = 360;
    localparam int QUARTER_TURN    = 90;
    localparam int SCALE_WIDTH     = 12;

    // Sine values are Q1.TRIG_FRAC_BITS and reach plus and minus one.
    localparam int TRIG_W = TRIG_FRAC_BITS + 2;
    // Coefficients carry sine, cosine, negated sine or an unsigned Q4.8 scale.
    localparam int COEF_W = ((TRIG_W > SCALE_WIDTH) ? TRIG_W : SCALE_WIDTH) + 1;
    // Coordinate differences and sums need one bit above a coordinate.
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = COEF_W + DIFF_W;
    localparam int SUM_W  = PROD_W + 2;

    localparam int COORD_MAX = 2 ** (COORD_WIDTH - 1) - 1;
    localparam int COORD_MIN = -(2 ** (COORD_WIDTH - 1));

    // Fixed-point constants of the series that builds the sine table.
    localparam int          QBITS  = 30;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef t_coord [NUM_COORDS-1:0]       t_vtx;
    typedef logic signed [TRIG_W-1:0]      t_trig;
    typedef logic signed [COEF_W-1:0]      t_coef;

    typedef enum logic [1:0] {
        MODE_LOAD      = 2'd0,
        MODE_TRANSLATE = 2'd1,
        MODE_ROTATE    = 2'd2,
        MODE_SCALE     = 2'd3
    } t_mode;

    // Fraction bits dropped after the products are summed.
    typedef enum logic [1:0] {
        SH_NONE  = 2'd0,
        SH_SCALE = 2'd1,
        SH_TRIG  = 2'd2
    } t_shift;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_DIFF = 3'd1,
        ST_MUL  = 3'd2,
        ST_SUM  = 3'd3,
        ST_FIN  = 3'd4
    } t_state;

    // One decoded request as the lanes see it: x' = a00*dx + a01*dy + px,
    // y' = a10*dx + a11*dy + py, the offsets scaled up by the fraction bits.
    typedef struct packed {
        t_mode  mode;
        t_shift sh;
        t_coord px;
        t_coord py;
        t_coef  a00;
        t_coef  a01;
        t_coef  a10;
        t_coef  a11;
    } t_cmd;

    localparam t_vtx VTX_RESET = {
        t_coord'(100), t_coord'(10), t_coord'(10),
        t_coord'(100), t_coord'(10), t_coord'(10)
    };

    typedef t_trig t_sin_tab [ANGLE_WRAP];

    // Sine of d degrees for d in 0 to 90, from a Taylor series in Q2.30,
    // rounded to TRIG_FRAC_BITS fraction bits.
    function automatic t_trig sin_quadrant(input int unsigned d);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        x    = (64'(d) * PI_Q30) / 64'd180;
        x2   = (x * x) >> QBITS;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> QBITS) / 64'd6;   sum = sum - signed'(term);
        term = ((term * x2) >> QBITS) / 64'd20;  sum = sum + signed'(term);
        term = ((term * x2) >> QBITS) / 64'd42;  sum = sum - signed'(term);
        term = ((term * x2) >> QBITS) / 64'd72;  sum = sum + signed'(term);
        term = ((term * x2) >> QBITS) / 64'd110; sum = sum - signed'(term);
        term = ((term * x2) >> QBITS) / 64'd156; sum = sum + signed'(term);
        term = ((term * x2) >> QBITS) / 64'd210; sum = sum - signed'(term);
        term = ((term * x2) >> QBITS) / 64'd272; sum = sum + signed'(term);
        if (sum < 0) begin
            sum = '0;
        end
        r = (unsigned'(sum) + (64'd1 << (QBITS - TRIG_FRAC_BITS - 1)))
            >> (QBITS - TRIG_FRAC_BITS);
        return TRIG_W'(r);
    endfunction

    // Full-turn table by quarter-wave symmetry; evaluated at elaboration.
    function automatic t_sin_tab build_sin_table();
        t_sin_tab tab;
        for (int d = 0; d < ANGLE_WRAP; d++) begin
            if (d <= 90) begin
                tab[d] = sin_quadrant(d);
            end else if (d <= 180) begin
                tab[d] = sin_quadrant(180 - d);
            end else if (d <= 270) begin
                tab[d] = -sin_quadrant(d - 180);
            end else begin
                tab[d] = -sin_quadrant(360 - d);
            end
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_TAB = build_sin_table();

endpackage

>>> hw/rtl/tat_lane.sv
// One vertex lane: difference, multiply, sum, then round toward zero and saturate.
// Depends on tat_pkg.
module tat_lane (
    input  logic            i_clk,
    input  tat_pkg::t_cmd   i_cmd,
    input  tat_pkg::t_coord i_vx,
    input  tat_pkg::t_coord i_vy,
    input  tat_pkg::t_coord i_ld_x,
    input  tat_pkg::t_coord i_ld_y,
    output tat_pkg::t_coord o_nx,
    output tat_pkg::t_coord o_ny
);
    import tat_pkg::*;

    logic signed [DIFF_W-1:0] n_dx, n_dy, r_dx, r_dy;
    logic signed [PROD_W-1:0] r_pxx, r_pxy, r_pyx, r_pyy;
    logic signed [SUM_W-1:0]  n_sx, n_sy, r_sx, r_sy;
    logic signed [SUM_W-1:0]  base_x, base_y;

    // Truncate toward zero by adding the dropped bits' mask to negative
    // values before the arithmetic shift, then clamp to the coordinate range.
    function automatic t_coord round_sat(input logic signed [SUM_W-1:0] v,
                                         input t_shift sh);
        logic signed [SUM_W-1:0] q;
        case (sh)
            SH_TRIG: begin
                q = (v + (v[SUM_W-1] ? SUM_W'((1 << TRIG_FRAC_BITS) - 1) : SUM_W'(0)))
                    >>> TRIG_FRAC_BITS;
            end
            SH_SCALE: begin
                q = (v + (v[SUM_W-1] ? SUM_W'((1 << SCALE_FRAC_BITS) - 1) : SUM_W'(0)))
                    >>> SCALE_FRAC_BITS;
            end
            default: begin
                q = v;
            end
        endcase
        if (q > SUM_W'(COORD_MAX)) begin
            q = SUM_W'(COORD_MAX);
        end else if (q < SUM_W'(COORD_MIN)) begin
            q = SUM_W'(COORD_MIN);
        end
        return q[COORD_WIDTH-1:0];
    endfunction

    always_comb begin
        case (i_cmd.mode)
            MODE_LOAD: begin
                n_dx = DIFF_W'(i_ld_x);
                n_dy = DIFF_W'(i_ld_y);
            end
            MODE_TRANSLATE: begin
                n_dx = DIFF_W'(i_vx) + DIFF_W'(i_cmd.px);
                n_dy = DIFF_W'(i_vy) + DIFF_W'(i_cmd.py);
            end
            default: begin
                n_dx = DIFF_W'(i_vx) - DIFF_W'(i_cmd.px);
                n_dy = DIFF_W'(i_vy) - DIFF_W'(i_cmd.py);
            end
        endcase
    end

    always_comb begin
        case (i_cmd.sh)
            SH_TRIG: begin
                base_x = SUM_W'(i_cmd.px) <<< TRIG_FRAC_BITS;
                base_y = SUM_W'(i_cmd.py) <<< TRIG_FRAC_BITS;
            end
            SH_SCALE: begin
                base_x = SUM_W'(i_cmd.px) <<< SCALE_FRAC_BITS;
                base_y = SUM_W'(i_cmd.py) <<< SCALE_FRAC_BITS;
            end
            default: begin
                base_x = '0;
                base_y = '0;
            end
        endcase
        n_sx = SUM_W'(r_pxx) + SUM_W'(r_pxy) + base_x;
        n_sy = SUM_W'(r_pyx) + SUM_W'(r_pyy) + base_y;
    end

    always_ff @(posedge i_clk) begin
        r_dx  <= n_dx;
        r_dy  <= n_dy;
        r_pxx <= i_cmd.a00 * r_dx;
        r_pxy <= i_cmd.a01 * r_dy;
        r_pyx <= i_cmd.a10 * r_dx;
        r_pyy <= i_cmd.a11 * r_dy;
        r_sx  <= n_sx;
        r_sy  <= n_sy;
    end

    assign o_nx = round_sat(r_sx, i_cmd.sh);
    assign o_ny = round_sat(r_sy, i_cmd.sh);

endmodule

>>> hw/rtl/tat_merge.sv
// Merging stage: gathers the lane results into the vertex store and the result register.
// Depends on tat_pkg.
module tat_merge (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_commit,
    input  tat_pkg::t_vtx i_new,
    output tat_pkg::t_vtx o_vtx,
    output logic          o_room,
    output logic          o_valid,
    input  logic          i_ready,
    output tat_pkg::t_vtx o_out
);
    import tat_pkg::*;

    t_vtx r_vtx;
    t_vtx r_out;
    logic r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtx   <= VTX_RESET;
            r_valid <= 1'b0;
        end else begin
            if (i_commit) begin
                r_vtx   <= i_new;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            r_out <= i_new;
        end
    end

    // A new result may be written when the register is empty or being emptied.
    assign o_room  = !r_valid || i_ready;
    assign o_vtx   = r_vtx;
    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

>>> hw/rtl/triangle_affine_transform_top.sv
// Top level of the triangle affine transform: request decode, sequencer, lanes and merge.
// Depends on tat_pkg, tat_lane and tat_merge.
//
// The block holds a triangle (x1,y1,x2,y2,x3,y3, reset to 10,10,100,10,10,100)
// and takes one request at a time: load new vertices, translate by point_x/y,
// rotate by angle_deg whole degrees about point_x/y, or scale by the unsigned
// Q4.8 factors scale_x/y about point_x/y. Angles of 360 and above wrap modulo
// 360. Every request returns all six coordinates as they stand afterwards,
// truncated toward zero and saturated to 16-bit signed. Three lanes, one per
// vertex, run a four-stage sequence (difference, multiply, sum, round and
// saturate) side by side; a merging stage writes the new vertices and the
// result register together. A request is accepted only while the sequencer is
// idle, and its result is registered once the sequencer has passed through its
// difference, multiply, sum and final states. If the previous result has not
// yet been taken, the sequencer holds in its last stage until there is room;
// a new request can still be accepted while a finished result waits on the
// output.
module triangle_affine_transform_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_mode,
    input  logic signed [15:0]              i_load_x1,
    input  logic signed [15:0]              i_load_y1,
    input  logic signed [15:0]              i_load_x2,
    input  logic signed [15:0]              i_load_y2,
    input  logic signed [15:0]              i_load_x3,
    input  logic signed [15:0]              i_load_y3,
    input  logic signed [15:0]              i_point_x,
    input  logic signed [15:0]              i_point_y,
    input  logic [tat_pkg::ANGLE_WIDTH-1:0] i_angle_deg,
    input  logic [tat_pkg::SCALE_WIDTH-1:0] i_scale_x,
    input  logic [tat_pkg::SCALE_WIDTH-1:0] i_scale_y,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [15:0]              o_out_x1,
    output logic signed [15:0]              o_out_y1,
    output logic signed [15:0]              o_out_x2,
    output logic signed [15:0]              o_out_y2,
    output logic signed [15:0]              o_out_x3,
    output logic signed [15:0]              o_out_y3
);
    import tat_pkg::*;

    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmd;
    t_vtx   r_ld;
    t_vtx   vtx, lane_out, res;
    logic   accept;
    logic   commit;
    logic   room;

    logic [ANGLE_WIDTH-1:0] ang_sin, ang_cos, ang_cos_raw;
    t_trig                  sin_v, cos_v;

    assign accept = i_in_valid && o_in_ready;

    // Wrap the angle once (it never exceeds twice the full turn), then find the
    // cosine as the sine a quarter turn further on.
    always_comb begin
        ang_sin = (i_angle_deg >= ANGLE_WIDTH'(ANGLE_WRAP))
                  ? i_angle_deg - ANGLE_WIDTH'(ANGLE_WRAP) : i_angle_deg;
        ang_cos_raw = ang_sin + ANGLE_WIDTH'(QUARTER_TURN);
        ang_cos = (ang_cos_raw >= ANGLE_WIDTH'(ANGLE_WRAP))
                  ? ang_cos_raw - ANGLE_WIDTH'(ANGLE_WRAP) : ang_cos_raw;
        sin_v = SIN_TAB[ang_sin];
        cos_v = SIN_TAB[ang_cos];
    end

    // Turn the request into the coefficients of one affine map. Load and
    // translate use the identity with no fraction bits.
    always_comb begin
        n_cmd.mode = t_mode'(i_mode);
        n_cmd.px   = i_point_x;
        n_cmd.py   = i_point_y;
        case (t_mode'(i_mode))
            MODE_ROTATE: begin
                n_cmd.sh  = SH_TRIG;
                n_cmd.a00 = COEF_W'(cos_v);
                n_cmd.a01 = -COEF_W'(sin_v);
                n_cmd.a10 = COEF_W'(sin_v);
                n_cmd.a11 = COEF_W'(cos_v);
            end
            MODE_SCALE: begin
                n_cmd.sh  = SH_SCALE;
                n_cmd.a00 = COEF_W'(i_scale_x);
                n_cmd.a01 = '0;
                n_cmd.a10 = '0;
                n_cmd.a11 = COEF_W'(i_scale_y);
            end
            default: begin
                n_cmd.sh  = SH_NONE;
                n_cmd.a00 = COEF_W'(1);
                n_cmd.a01 = '0;
                n_cmd.a10 = '0;
                n_cmd.a11 = COEF_W'(1);
            end
        endcase
    end

    // The decoded request and the load coordinates stay put until the next
    // request, which cannot arrive before this one has been committed.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
            r_ld  <= {i_load_y3, i_load_x3, i_load_y2, i_load_x2, i_load_y1, i_load_x1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The lane stages run every cycle; the sequencer only counts until the
    // last stage holds this request's result and the result register has room.
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        commit     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_DIFF;
                end
            end
            ST_DIFF: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_SUM;
            end
            ST_SUM: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (room) begin
                    commit  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    for (genvar g = 0; g < NUM_VERTICES; g++) begin : g_lane
        tat_lane u_lane (
            .i_clk  (i_clk),
            .i_cmd  (r_cmd),
            .i_vx   (vtx[2*g]),
            .i_vy   (vtx[2*g+1]),
            .i_ld_x (r_ld[2*g]),
            .i_ld_y (r_ld[2*g+1]),
            .o_nx   (lane_out[2*g]),
            .o_ny   (lane_out[2*g+1])
        );
    end

    tat_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_commit(commit),
        .i_new   (lane_out),
        .o_vtx   (vtx),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_out   (res)
    );

    assign o_out_x1 = res[0];
    assign o_out_y1 = res[1];
    assign o_out_x2 = res[2];
    assign o_out_y2 = res[3];
    assign o_out_x3 = res[4];
    assign o_out_y3 = res[5];

endmodule

>>> hw/rtl/tat_checker.sv
// Port-level checks of the triangle affine transform, bound to its top level.
// Depends on triangle_affine_transform_top's ports only.
module tat_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] o_out_x1,
    input logic signed [15:0] o_out_y1,
    input logic signed [15:0] o_out_x2,
    input logic signed [15:0] o_out_y2,
    input logic signed [15:0] o_out_x3,
    input logic signed [15:0] o_out_y3
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result withdrawn before it was taken");

    // A stalled result keeps its coordinates.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_x1) && $stable(o_out_y1)
            && $stable(o_out_x2) && $stable(o_out_y2)
            && $stable(o_out_x3) && $stable(o_out_y3))
        else $error("stalled result changed");

    // Only one request is in work at a time.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request accepted while one is in work");

    // A result that appears on an empty output comes from the request
    // accepted before the difference, multiply, sum and final states ran.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 5))
        else $error("result appeared without a matching request");

endmodule

bind triangle_affine_transform_top tat_checker u_tat_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_x1    (o_out_x1),
    .o_out_y1    (o_out_y1),
    .o_out_x2    (o_out_x2),
    .o_out_y2    (o_out_y2),
    .o_out_x3    (o_out_x3),
    .o_out_y3    (o_out_y3)
);
